// ===== sv/svgm_pkg.sv =====
// Shared types and constants of the stereo voice gain matrix.
package svgm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASTER_VOLUME   = 2'd0,
        REG_MASTER_PAN      = 2'd1,
        REG_MASTER_BALANCE  = 2'd2,
        REG_MASTER_SURROUND = 2'd3
    } cfg_idx_t;

    typedef logic        [6:0] mvol_t;
    typedef logic signed [7:0] mpan_t;
    typedef logic        [8:0] vvol_t;
    typedef logic signed [8:0] vpan_t;
    typedef logic signed [9:0] gain_t;
    typedef logic        [7:0] coef_t;
    typedef logic        [6:0] factor_t;
    typedef logic        [8:0] share_t;
    typedef logic       [15:0] prod_t;
    typedef logic signed [17:0] rowsum_t;

    typedef struct packed {
        coef_t m00;
        coef_t m01;
        coef_t m10;
        coef_t m11;
    } matrix_t;

    typedef struct packed {
        share_t share_l;
        share_t share_r;
        logic   invert;
        logic   mute;
    } share_item_t;

    localparam mvol_t   MVOL_FULL    = 7'd64;
    localparam mpan_t   MPAN_LIM     = 8'sd64;
    localparam coef_t   COEF_UNITY   = 8'd64;
    localparam factor_t FACTOR_UNITY = 7'd64;
    localparam vvol_t   VVOL_MAX     = 9'd256;
    localparam vpan_t   VPAN_MAX     = 9'sd128;
    localparam vpan_t   VPAN_MIN     = -9'sd128;
    localparam rowsum_t CLAMP_LIM    = 18'sd65536;
    localparam logic signed [18:0] ROUND_BIAS = 19'sd192;
    localparam gain_t   GAIN_MAX     = 10'sd256;
    localparam gain_t   GAIN_MIN     = -10'sd256;

endpackage

// ===== sv/svgm_if.sv =====
// Channel interfaces: configuration writes, voice items and gain results.
interface svgm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [svgm_pkg::CFG_IDX_W-1:0]      index;
    logic [svgm_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface svgm_voice_if;
    logic            valid;
    logic            ready;
    svgm_pkg::vvol_t voice_volume;
    svgm_pkg::vpan_t voice_pan;
    logic            voice_surround;
    logic            voice_mute;

    modport source (output valid, output voice_volume, output voice_pan,
                    output voice_surround, output voice_mute, input ready);
    modport sink   (input valid, input voice_volume, input voice_pan,
                    input voice_surround, input voice_mute, output ready);
endinterface

interface svgm_gain_if;
    logic            valid;
    logic            ready;
    svgm_pkg::gain_t gain_left;
    svgm_pkg::gain_t gain_right;
    svgm_pkg::gain_t target_left;
    svgm_pkg::gain_t target_right;

    modport source (output valid, output gain_left, output gain_right,
                    output target_left, output target_right, input ready);
    modport sink   (input valid, input gain_left, input gain_right,
                    input target_left, input target_right, output ready);
endinterface

// ===== sv/svgm_cfg.sv =====
// Master registers and the two-stage build of the 2x2 gain matrix.
module svgm_cfg (
    input  logic              clk,
    input  logic              rst_n,
    svgm_cfg_if.sink          cfg,
    output svgm_pkg::matrix_t matrix,
    output logic              surround
);
    import svgm_pkg::*;

    mvol_t   mvol_reg, mvol_next;
    mpan_t   mpan_reg, mpan_next;
    mpan_t   mbal_reg, mbal_next;
    logic    msur_reg, msur_next;
    mpan_t   wr_s;

    logic signed [8:0] pan_pos, pan_neg, bal_l, bal_r;
    logic [14:0] base_a_prod, base_b_prod;
    coef_t   base_a_reg, base_b_reg;
    factor_t fac_l, fac_r;
    logic [14:0] p00, p01, p10, p11;
    matrix_t matrix_reg;

    assign cfg.ready = 1'b1;
    assign wr_s = mpan_t'(cfg.data);

    always_comb
    begin
        mvol_next = mvol_reg;
        mpan_next = mpan_reg;
        mbal_next = mbal_reg;
        msur_next = msur_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_MASTER_VOLUME:
                begin
                    if (cfg.data[6:0] <= MVOL_FULL)
                        mvol_next = cfg.data[6:0];
                end
                REG_MASTER_PAN:
                begin
                    if (wr_s >= -MPAN_LIM && wr_s <= MPAN_LIM)
                        mpan_next = wr_s;
                end
                REG_MASTER_BALANCE:
                begin
                    if (wr_s >= -MPAN_LIM && wr_s <= MPAN_LIM)
                        mbal_next = wr_s;
                end
                REG_MASTER_SURROUND:
                    msur_next = cfg.data[0];
                default:
                    msur_next = msur_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvol_reg <= MVOL_FULL;
            mpan_reg <= '0;
            mbal_reg <= '0;
            msur_reg <= 1'b0;
        end
        else
        begin
            mvol_reg <= mvol_next;
            mpan_reg <= mpan_next;
            mbal_reg <= mbal_next;
            msur_reg <= msur_next;
        end
    end

    // Volume split by master pan
    assign pan_pos     = 9'sd64 + 9'(mpan_reg);
    assign pan_neg     = 9'sd64 - 9'(mpan_reg);
    assign base_a_prod = 15'(mvol_reg) * 15'(pan_pos[7:0]);
    assign base_b_prod = 15'(mvol_reg) * 15'(pan_neg[7:0]);

    // Balance attenuates one row only
    assign bal_l = 9'sd64 - 9'(mbal_reg);
    assign bal_r = 9'sd64 + 9'(mbal_reg);
    assign fac_l = (mbal_reg > 8'sd0) ? bal_l[6:0] : FACTOR_UNITY;
    assign fac_r = (mbal_reg < 8'sd0) ? bal_r[6:0] : FACTOR_UNITY;

    assign p00 = 15'(base_a_reg) * 15'(fac_l);
    assign p01 = 15'(base_b_reg) * 15'(fac_l);
    assign p10 = 15'(base_b_reg) * 15'(fac_r);
    assign p11 = 15'(base_a_reg) * 15'(fac_r);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_a_reg <= COEF_UNITY;
            base_b_reg <= COEF_UNITY;
            matrix_reg <= '{m00: COEF_UNITY, m01: COEF_UNITY,
                            m10: COEF_UNITY, m11: COEF_UNITY};
        end
        else
        begin
            base_a_reg     <= base_a_prod[13:6];
            base_b_reg     <= base_b_prod[13:6];
            matrix_reg.m00 <= p00[13:6];
            matrix_reg.m01 <= p01[13:6];
            matrix_reg.m10 <= p10[13:6];
            matrix_reg.m11 <= p11[13:6];
        end
    end

    assign matrix   = matrix_reg;
    assign surround = msur_reg;

endmodule

// ===== sv/svgm_front.sv =====
// Voice front end: saturate volume and pan, then split into left and right shares.
module svgm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    svgm_voice_if.sink            voice,
    input  logic                  surround,
    output logic                  dn_valid,
    output svgm_pkg::share_item_t dn_item,
    input  logic                  dn_ready
);
    import svgm_pkg::*;

    logic  v1_reg, v1_next, v2_reg, v2_next;
    logic  adv1, adv2;
    vvol_t vol_sat, vol1_reg;
    vpan_t pan_sat, pan1_reg;
    logic  inv1_reg, mute1_reg;
    logic signed [9:0] sum_r, sum_l;
    logic [17:0] prod_r, prod_l;
    share_item_t item2_reg;

    assign adv2 = !v2_reg || dn_ready;
    assign adv1 = !v1_reg || adv2;
    assign voice.ready = adv1;

    assign vol_sat = (voice.voice_volume > VVOL_MAX) ? VVOL_MAX : voice.voice_volume;

    always_comb
    begin
        pan_sat = voice.voice_pan;
        if (voice.voice_pan > VPAN_MAX)
            pan_sat = VPAN_MAX;
        else if (voice.voice_pan < VPAN_MIN)
            pan_sat = VPAN_MIN;
    end

    assign sum_r  = 10'sd128 + 10'(pan1_reg);
    assign sum_l  = 10'sd128 - 10'(pan1_reg);
    assign prod_r = 18'(vol1_reg) * 18'(sum_r[8:0]);
    assign prod_l = 18'(vol1_reg) * 18'(sum_l[8:0]);

    assign v1_next = adv1 ? voice.valid : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            vol1_reg  <= vol_sat;
            pan1_reg  <= pan_sat;
            inv1_reg  <= voice.voice_surround ^ surround;
            mute1_reg <= voice.voice_mute;
        end
        if (adv2)
        begin
            item2_reg.share_l <= prod_l[16:8];
            item2_reg.share_r <= prod_r[16:8];
            item2_reg.invert  <= inv1_reg;
            item2_reg.mute    <= mute1_reg;
        end
    end

    assign dn_valid = v2_reg;
    assign dn_item  = item2_reg;

endmodule

// ===== sv/svgm_back.sv =====
// Matrix back end: products, row sums with phase flip, round and clamp, output register.
module svgm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    input  svgm_pkg::share_item_t up_item,
    output logic                  up_ready,
    input  svgm_pkg::matrix_t     matrix,
    svgm_gain_if.source           gain
);
    import svgm_pkg::*;

    logic    v3_reg, v3_next, v4_reg, v4_next, v5_reg, v5_next;
    logic    adv3, adv4, adv5;
    logic [16:0] q00, q01, q10, q11;
    prod_t   p00_reg, p01_reg, p10_reg, p11_reg;
    logic    inv3_reg, mute3_reg, mute4_reg;
    logic [16:0] row_l, row_r;
    rowsum_t vl_reg, vr_reg;
    gain_t   gl_reg, gr_reg, tl_reg, tr_reg;
    gain_t   gl_next, gr_next;

    function automatic gain_t round_clamp(input rowsum_t v);
        logic signed [18:0] b;
        b = 19'(v) + ROUND_BIAS;
        if (v > CLAMP_LIM)
            return GAIN_MAX;
        else if (v < -CLAMP_LIM)
            return GAIN_MIN;
        return gain_t'(b[17:8]);
    endfunction

    assign adv5 = !v5_reg || gain.ready;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign up_ready = adv3;

    assign q00 = 17'(matrix.m00) * 17'(up_item.share_l);
    assign q01 = 17'(matrix.m01) * 17'(up_item.share_r);
    assign q10 = 17'(matrix.m10) * 17'(up_item.share_l);
    assign q11 = 17'(matrix.m11) * 17'(up_item.share_r);

    assign row_l = 17'(p00_reg) + 17'(p01_reg);
    assign row_r = 17'(p10_reg) + 17'(p11_reg);

    assign gl_next = round_clamp(vl_reg);
    assign gr_next = round_clamp(vr_reg);

    assign v3_next = adv3 ? up_valid : v3_reg;
    assign v4_next = adv4 ? v3_reg : v4_reg;
    assign v5_next = adv5 ? v4_reg : v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            p00_reg   <= q00[15:0];
            p01_reg   <= q01[15:0];
            p10_reg   <= q10[15:0];
            p11_reg   <= q11[15:0];
            inv3_reg  <= up_item.invert;
            mute3_reg <= up_item.mute;
        end
        if (adv4)
        begin
            vl_reg    <= rowsum_t'(row_l);
            vr_reg    <= inv3_reg ? -rowsum_t'(row_r) : rowsum_t'(row_r);
            mute4_reg <= mute3_reg;
        end
        if (adv5)
        begin
            gl_reg <= gl_next;
            gr_reg <= gr_next;
            tl_reg <= mute4_reg ? '0 : gl_next;
            tr_reg <= mute4_reg ? '0 : gr_next;
        end
    end

    assign gain.valid        = v5_reg;
    assign gain.gain_left    = gl_reg;
    assign gain.gain_right   = gr_reg;
    assign gain.target_left  = tl_reg;
    assign gain.target_right = tr_reg;

endmodule

// ===== sv/stereo_voice_gain_matrix.sv =====
// Top level of the stereo voice gain matrix.
//
// Channels: cfg takes register writes (index 0 master volume, 1 master pan,
// 2 master balance, 3 master surround); its ready is always high and an
// out-of-range value leaves the register unchanged. voice takes one voice item
// per transfer; gain delivers one result per voice, in order.
// Throughput: one voice per cycle while gain.ready is high, through five
// register stages (saturate, share multiply, matrix multiply, row sum, round
// and clamp into the output register). The matrix itself is rebuilt from the
// master registers in two stages, ahead of any voice accepted after a write
// reaching the matrix multiply.
// Reset: master volume 64, pan 0, balance 0, surround off; pipeline empty.
// Stall: when gain.ready is low the output holds, earlier stages fill their
// bubbles, and voice.ready drops only when every stage is occupied.
module stereo_voice_gain_matrix (
    input  logic        clk,
    input  logic        rst_n,
    svgm_cfg_if.sink    cfg,
    svgm_voice_if.sink  voice,
    svgm_gain_if.source gain
);
    import svgm_pkg::*;

    matrix_t     matrix;
    logic        surround;
    logic        mid_valid;
    logic        mid_ready;
    share_item_t mid_item;

    svgm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .matrix   (matrix),
        .surround (surround)
    );

    svgm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .voice    (voice),
        .surround (surround),
        .dn_valid (mid_valid),
        .dn_item  (mid_item),
        .dn_ready (mid_ready)
    );

    svgm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mid_valid),
        .up_item  (mid_item),
        .up_ready (mid_ready),
        .matrix   (matrix),
        .gain     (gain)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the stereo voice gain matrix with a built-in gain predictor.
module testbench;
    import svgm_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 150;

    typedef struct packed {
        gain_t gain_left;
        gain_t gain_right;
        gain_t target_left;
        gain_t target_right;
    } gain_set_t;

    logic clk;
    logic rst_n;

    svgm_cfg_if   cfg_if();
    svgm_voice_if voice_if();
    svgm_gain_if  gain_if();

    stereo_voice_gain_matrix u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .voice (voice_if),
        .gain  (gain_if)
    );

    int        cur_volume;
    int        cur_pan;
    int        cur_balance;
    logic      cur_surround;
    gain_set_t pending_gains[$];
    int        mismatches;
    int        quiet_cycles;
    bit        src_idle_en;
    bit        sink_idle_en;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic gain_t round_gain(int row);
        if (row > 65536)
            return GAIN_MAX;
        if (row < -65536)
            return GAIN_MIN;
        return gain_t'((row + 192) >>> 8);
    endfunction

    function automatic gain_set_t predict_gains(vvol_t vol_in, vpan_t pan_in,
                                                logic sur, logic mute);
        int        m00, m01, m10, m11;
        int        vol, pan, share_l, share_r, row_l, row_r;
        gain_set_t res;
        m00 = (cur_volume * (64 + cur_pan)) >>> 6;
        m01 = (cur_volume * (64 - cur_pan)) >>> 6;
        m11 = m00;
        m10 = m01;
        if (cur_balance > 0)
        begin
            m00 = (m00 * (64 - cur_balance)) >>> 6;
            m01 = (m01 * (64 - cur_balance)) >>> 6;
        end
        else if (cur_balance < 0)
        begin
            m10 = (m10 * (64 + cur_balance)) >>> 6;
            m11 = (m11 * (64 + cur_balance)) >>> 6;
        end
        vol = (vol_in > 256) ? 256 : int'(vol_in);
        pan = pan_in;
        if (pan > 128)
            pan = 128;
        if (pan < -128)
            pan = -128;
        share_r = (vol * (128 + pan)) >>> 8;
        share_l = (vol * (128 - pan)) >>> 8;
        row_l = m00 * share_l + m01 * share_r;
        row_r = m10 * share_l + m11 * share_r;
        if (sur ^ cur_surround)
            row_r = -row_r;
        res.gain_left    = round_gain(row_l);
        res.gain_right   = round_gain(row_r);
        res.target_left  = mute ? gain_t'(0) : res.gain_left;
        res.target_right = mute ? gain_t'(0) : res.gain_right;
        return res;
    endfunction

    // Write all four registers in index order; valid stays high across the burst.
    task automatic write_config(logic [7:0] vol, logic [7:0] pan, logic [7:0] bal,
                                logic [7:0] sur);
        logic [7:0] vals [4];
        cfg_idx_t   idx;
        int         s;
        vals = '{vol, pan, bal, sur};
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_idx_t'(i);
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx;
            cfg_if.data  <= vals[i];
            do @(posedge clk); while (!cfg_if.ready);
            s = mpan_t'(vals[i]);
            case (idx)
                REG_MASTER_VOLUME:
                    if (vals[i][6:0] <= 7'd64)
                        cur_volume = vals[i][6:0];
                REG_MASTER_PAN:
                    if (s >= -64 && s <= 64)
                        cur_pan = s;
                REG_MASTER_BALANCE:
                    if (s >= -64 && s <= 64)
                        cur_balance = s;
                REG_MASTER_SURROUND:
                    cur_surround = vals[i][0];
                default:
                    ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_voice(vvol_t vol, vpan_t pan, logic sur, logic mute);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            voice_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        voice_if.valid          <= 1'b1;
        voice_if.voice_volume   <= vol;
        voice_if.voice_pan      <= pan;
        voice_if.voice_surround <= sur;
        voice_if.voice_mute     <= mute;
        do @(posedge clk); while (!voice_if.ready);
        pending_gains.push_back(predict_gains(vol, pan, sur, mute));
    endtask

    task automatic send_random_voice();
        vvol_t vol;
        vpan_t pan;
        if ($urandom_range(0, 3) == 0)
            vol = vvol_t'($urandom_range(250, 262));
        else
            vol = vvol_t'($urandom_range(0, 511));
        if ($urandom_range(0, 3) == 0)
            pan = $urandom_range(0, 1) ? vpan_t'($urandom_range(118, 138))
                                       : -vpan_t'($urandom_range(118, 138));
        else
            pan = vpan_t'($urandom_range(0, 511));
        send_voice(vol, pan, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Hold the sender until every expected result has come back.
    task automatic wait_idle();
        voice_if.valid <= 1'b0;
        do @(posedge clk); while (pending_gains.size() != 0);
    endtask

    function automatic logic [7:0] rand_reg_value(bit is_signed);
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        if (is_signed)
            return 8'(int'($urandom_range(0, 128)) - 64);
        return {1'($urandom_range(0, 1)), 7'($urandom_range(0, 64))};
    endfunction

    task automatic test_reset_defaults();
        send_voice(9'd0,   9'sd0,    1'b0, 1'b0);
        send_voice(9'd256, 9'sd0,    1'b0, 1'b0);
        send_voice(9'd257, 9'sd0,    1'b1, 1'b0);
        send_voice(9'd511, -9'sd256, 1'b1, 1'b1);
        send_voice(9'd511, 9'sd255,  1'b0, 1'b0);
        send_voice(9'd300, -9'sd128, 1'b0, 1'b1);
        send_voice(9'd200, 9'sd128,  1'b1, 1'b0);
        send_voice(9'd256, -9'sd129, 1'b0, 1'b0);
        send_voice(9'd256, 9'sd129,  1'b1, 1'b1);
        send_voice(9'd128, -9'sd1,   1'b0, 1'b0);
        send_voice(9'd1,   9'sd1,    1'b0, 1'b1);
        send_voice(9'h155, 9'h0AA,   1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_register_writes();
        write_config(8'd64, 8'd64, 8'd64, 8'd1);
        send_voice(9'd256, 9'sd0,    1'b0, 1'b0);
        send_voice(9'd256, -9'sd128, 1'b1, 1'b0);
        send_voice(9'd511, 9'sd128,  1'b0, 1'b1);
        wait_idle();
        write_config(8'd0, -8'sd64, -8'sd64, 8'd0);
        send_voice(9'd256, 9'sd0,   1'b0, 1'b0);
        send_voice(9'd511, 9'sd255, 1'b1, 1'b0);
        wait_idle();
        // out-of-range volume, pan and balance values must leave those registers alone
        write_config(8'd65, 8'd65, -8'sd65, 8'hFE);
        send_voice(9'd256, 9'sd64,  1'b0, 1'b0);
        send_voice(9'd256, -9'sd64, 1'b1, 1'b0);
        wait_idle();
        write_config(8'hC0, 8'h80, 8'h7F, 8'hFF);
        send_voice(9'd256, 9'sd64,  1'b0, 1'b0);
        send_voice(9'd256, -9'sd64, 1'b1, 1'b1);
        wait_idle();
        write_config(8'h7F, -8'sd64, 8'sd64, 8'h01);
        send_voice(9'd256, 9'sd100, 1'b0, 1'b0);
        send_voice(9'd180, -9'sd30, 1'b1, 1'b0);
        send_voice(9'd256, 9'sd0,   1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: write_config(8'd64, 8'd0, 8'd0, 8'd0);
                1: write_config(8'd64, 8'sd64, 8'sd64, 8'd0);
                2: write_config(8'd0, -8'sd64, -8'sd64, 8'd1);
                default: write_config(rand_reg_value(1'b0), rand_reg_value(1'b1),
                                      rand_reg_value(1'b1), 8'($urandom_range(0, 255)));
            endcase
            src_idle_en  = (phase % 4) != 3;
            sink_idle_en = (phase % 4) != 2;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 4 && n == PHASE_ITEMS / 2)
                    wait_idle();
                send_random_voice();
            end
            wait_idle();
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        cfg_if.valid            <= 1'b0;
        cfg_if.index            <= '0;
        cfg_if.data             <= '0;
        voice_if.valid          <= 1'b0;
        voice_if.voice_volume   <= '0;
        voice_if.voice_pan      <= '0;
        voice_if.voice_surround <= 1'b0;
        voice_if.voice_mute     <= 1'b0;
        cur_volume   = 64;
        cur_pan      = 0;
        cur_balance  = 0;
        cur_surround = 1'b0;
        mismatches   = 0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_writes();
        test_random_phases();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += pending_gains.size();
        if (mismatches == 0)
            $display("** stereo_voice_gain_matrix: PASSED **");
        else
            $display("** stereo_voice_gain_matrix: FAILED **");
        $finish;
    end

    initial
    begin
        int stall;
        gain_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_idle_en ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                gain_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            gain_if.ready <= 1'b1;
            do @(posedge clk); while (!gain_if.valid);
        end
    end

    always @(posedge clk)
    begin
        gain_set_t want;
        gain_set_t got;
        if (rst_n && gain_if.valid && gain_if.ready)
        begin
            got = '{gain_if.gain_left, gain_if.gain_right,
                    gain_if.target_left, gain_if.target_right};
            if (pending_gains.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected transfer gl=%0d gr=%0d tl=%0d tr=%0d",
                             $realtime, got.gain_left, got.gain_right,
                             got.target_left, got.target_right);
                mismatches++;
            end
            else
            begin
                want = pending_gains.pop_front();
                if (got.gain_left !== want.gain_left || got.gain_right !== want.gain_right
                    || got.target_left !== want.target_left
                    || got.target_right !== want.target_right)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: mismatch expected gl=%0d gr=%0d tl=%0d tr=%0d",
                                 $realtime, want.gain_left, want.gain_right,
                                 want.target_left, want.target_right);
                        $display("    actual gl=%0d gr=%0d tl=%0d tr=%0d",
                                 got.gain_left, got.gain_right,
                                 got.target_left, got.target_right);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cfg_if.valid && cfg_if.ready) || (voice_if.valid && voice_if.ready)
            || (gain_if.valid && gain_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("** stereo_voice_gain_matrix: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
